>>> hdl/tnd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnd_pkg
// Shared types and codes for the two-level name directory: request opcodes,
// result status codes and the control bundles between sequencer and tables.
// ----------------------------------------------------------------------------
package tnd_pkg;

  // Fixed field widths of the stream payload.
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned STATUS_W  = 4;
  localparam int unsigned OUT_IDX_W = 4;

  // Request opcodes.
  typedef enum logic [OP_W-1:0] {
    OP_MKDIR  = 2'd0,
    OP_MKFILE = 2'd1,
    OP_RMFILE = 2'd2,
    OP_FIND   = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_DIR_CREATED    = 4'd0,
    ST_DIR_EXISTS     = 4'd1,
    ST_DIR_TABLE_FULL = 4'd2,
    ST_FILE_CREATED   = 4'd3,
    ST_FILE_EXISTS    = 4'd4,
    ST_DIR_FULL       = 4'd5,
    ST_DELETED        = 4'd6,
    ST_FOUND          = 4'd7,
    ST_FILE_MISSING   = 4'd8,
    ST_DIR_MISSING    = 4'd9
  } status_e;

  // Sequencer commands to a name table.
  typedef struct packed {
    logic start;
    logic run;
    logic rd_en;
  } scan_ctl_t;

  // Scan outcome reported by a name table.
  typedef struct packed {
    logic hit;
    logic miss;
  } scan_res_t;

endpackage

>>> hdl/tnd_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnd_table
// Name memory with a linear search engine. One read is issued per cycle while
// run is held and the registered read data is compared with the key in the next
// cycle. A direct read and an independent write port serve the read-modify-write
// steps of the sequencer.
// ----------------------------------------------------------------------------
module tnd_table
  import tnd_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned IW    = 5,
  parameter int unsigned KW    = 64,
  parameter int unsigned DW    = 69
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  scan_ctl_t     ctl_i,
  output scan_res_t     res_o,
  input  logic [KW-1:0] key_i,
  input  logic [IW-1:0] limit_i,
  input  logic [AW-1:0] base_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [IW-1:0] idx_o,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;
  logic [IW-1:0] idx_q;
  logic [IW-1:0] cmp_idx_q;
  logic          cmp_v_q;
  logic          hit;
  logic          issue;
  logic [AW-1:0] raddr;

  // Compare the entry read last cycle; issue the next read while entries remain.
  assign hit   = ctl_i.run && cmp_v_q && (rdata_q[KW-1:0] == key_i);
  assign issue = ctl_i.run && !hit && (idx_q != limit_i);
  assign raddr = issue ? (base_i + AW'(idx_q)) : rd_addr_i;

  assign res_o.hit  = hit;
  assign res_o.miss = ctl_i.run && !hit && (idx_q == limit_i);
  assign idx_o      = cmp_idx_q;
  assign rdata_o    = rdata_q;

  // Memory with one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (issue || ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
    if (issue) begin
      cmp_idx_q <= idx_q;
    end
  end

  // Search counter and compare-valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      cmp_v_q <= 1'b0;
    end else begin
      cmp_v_q <= issue;
      if (ctl_i.start) begin
        idx_q <= '0;
      end else if (issue) begin
        idx_q <= idx_q + IW'(1);
      end
    end
  end

  // A read is only issued for an entry below the limit.
  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (idx_q < limit_i))
    else $error("tnd_table: read issued beyond the entry count");

  // A reported match lies below the limit.
  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> (cmp_idx_q < limit_i))
    else $error("tnd_table: match reported beyond the entry count");

  // Restart and stepping never coincide.
  a_start_not_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.start && ctl_i.run))
    else $error("tnd_table: search restarted while running");

endmodule

>>> hdl/tnd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnd_ctrl
// Request sequencer. It searches the directory table, then, for file requests,
// the file list of the matched directory, decides the status, performs the
// writes and loads the output register.
// ----------------------------------------------------------------------------
module tnd_ctrl
  import tnd_pkg::*;
#(
  parameter int unsigned DIR_SLOTS  = 16,
  parameter int unsigned FILE_SLOTS = 16,
  parameter int unsigned NAME_BYTES = 8,
  localparam int unsigned NAME_W    = 8 * NAME_BYTES,
  localparam int unsigned DAW       = $clog2(DIR_SLOTS),
  localparam int unsigned DCW       = $clog2(DIR_SLOTS + 1),
  localparam int unsigned FAW       = $clog2(FILE_SLOTS),
  localparam int unsigned FCW       = $clog2(FILE_SLOTS + 1),
  localparam int unsigned MAW       = $clog2(DIR_SLOTS * FILE_SLOTS),
  localparam int unsigned DDW       = FCW + NAME_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Request side
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  logic [OP_W-1:0]      req_op_i,
  input  logic [KEY_W-1:0]     req_dir_key_i,
  input  logic [KEY_W-1:0]     req_file_key_i,
  // Result side
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  output logic [STATUS_W-1:0]  rsp_status_o,
  output logic [OUT_IDX_W-1:0] rsp_dir_o,
  output logic [OUT_IDX_W-1:0] rsp_slot_o,
  // Directory table
  output scan_ctl_t            dir_ctl_o,
  input  scan_res_t            dir_res_i,
  input  logic [DCW-1:0]       dir_idx_i,
  input  logic [DDW-1:0]       dir_rdata_i,
  output logic [DCW-1:0]       dir_limit_o,
  output logic [NAME_W-1:0]    dir_key_o,
  output logic                 dir_we_o,
  output logic [DAW-1:0]       dir_waddr_o,
  output logic [DDW-1:0]       dir_wdata_o,
  // File table
  output scan_ctl_t            file_ctl_o,
  input  scan_res_t            file_res_i,
  input  logic [FCW-1:0]       file_idx_i,
  input  logic [NAME_W-1:0]    file_rdata_i,
  output logic [FCW-1:0]       file_limit_o,
  output logic [MAW-1:0]       file_base_o,
  output logic [MAW-1:0]       file_rd_addr_o,
  output logic [NAME_W-1:0]    file_key_o,
  output logic                 file_we_o,
  output logic [MAW-1:0]       file_waddr_o,
  output logic [NAME_W-1:0]    file_wdata_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DSCAN  = 6'b000010,
    S_FSCAN  = 6'b000100,
    S_DEL_RD = 6'b001000,
    S_DEL_WR = 6'b010000,
    S_RESP   = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  op_e                   op_q, op_d;
  logic [NAME_W-1:0]     dkey_q, dkey_d;
  logic [NAME_W-1:0]     fkey_q, fkey_d;
  logic [DCW-1:0]        dirs_q, dirs_d;
  logic [DAW-1:0]        d_q, d_d;
  logic [FCW-1:0]        cnt_q, cnt_d;
  logic [MAW-1:0]        base_q, base_d;
  logic [FAW-1:0]        f_q, f_d;
  status_e               res_status_q, res_status_d;
  logic [OUT_IDX_W-1:0]  res_dir_q, res_dir_d;
  logic [OUT_IDX_W-1:0]  res_slot_q, res_slot_d;
  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   out_status_q, out_status_d;
  logic [OUT_IDX_W-1:0]  out_dir_q, out_dir_d;
  logic [OUT_IDX_W-1:0]  out_slot_q, out_slot_d;
  logic                  accept;

  assign req_ready_o  = (state_q == S_IDLE);
  assign accept       = req_valid_i && req_ready_o;
  assign rsp_valid_o  = out_valid_q;
  assign rsp_status_o = out_status_q;
  assign rsp_dir_o    = out_dir_q;
  assign rsp_slot_o   = out_slot_q;

  assign dir_limit_o    = dirs_q;
  assign dir_key_o      = dkey_q;
  assign file_limit_o   = cnt_q;
  assign file_base_o    = base_q;
  assign file_key_o     = fkey_q;
  assign file_rd_addr_o = base_q + MAW'(cnt_q) - MAW'(1);

  // Sequencer: search, decide, write back, respond.
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    dkey_d       = dkey_q;
    fkey_d       = fkey_q;
    dirs_d       = dirs_q;
    d_d          = d_q;
    cnt_d        = cnt_q;
    base_d       = base_q;
    f_d          = f_q;
    res_status_d = res_status_q;
    res_dir_d    = res_dir_q;
    res_slot_d   = res_slot_q;
    out_valid_d  = out_valid_q && !rsp_ready_i;
    out_status_d = out_status_q;
    out_dir_d    = out_dir_q;
    out_slot_d   = out_slot_q;
    dir_ctl_o    = '0;
    file_ctl_o   = '0;
    dir_we_o     = 1'b0;
    dir_waddr_o  = d_q;
    dir_wdata_o  = {cnt_q, dkey_q};
    file_we_o    = 1'b0;
    file_waddr_o = base_q + MAW'(cnt_q);
    file_wdata_o = fkey_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d            = op_e'(req_op_i);
          dkey_d          = req_dir_key_i[NAME_W-1:0];
          fkey_d          = req_file_key_i[NAME_W-1:0];
          dir_ctl_o.start = 1'b1;
          state_d         = S_DSCAN;
        end
      end

      S_DSCAN: begin
        dir_ctl_o.run = 1'b1;
        if (dir_res_i.hit) begin
          d_d        = DAW'(dir_idx_i);
          cnt_d      = dir_rdata_i[DDW-1:NAME_W];
          base_d     = MAW'(dir_idx_i) * MAW'(FILE_SLOTS);
          res_dir_d  = OUT_IDX_W'(dir_idx_i);
          res_slot_d = '0;
          if (op_q == OP_MKDIR) begin
            res_status_d = ST_DIR_EXISTS;
            state_d      = S_RESP;
          end else begin
            file_ctl_o.start = 1'b1;
            state_d          = S_FSCAN;
          end
        end else if (dir_res_i.miss) begin
          res_dir_d  = '0;
          res_slot_d = '0;
          state_d    = S_RESP;
          if (op_q != OP_MKDIR) begin
            res_status_d = ST_DIR_MISSING;
          end else if (dirs_q == DCW'(DIR_SLOTS)) begin
            res_status_d = ST_DIR_TABLE_FULL;
          end else begin
            // New directory starts with no files.
            dir_we_o     = 1'b1;
            dir_waddr_o  = DAW'(dirs_q);
            dir_wdata_o  = {FCW'(0), dkey_q};
            dirs_d       = dirs_q + DCW'(1);
            res_status_d = ST_DIR_CREATED;
            res_dir_d    = OUT_IDX_W'(dirs_q);
          end
        end
      end

      S_FSCAN: begin
        file_ctl_o.run = 1'b1;
        if (file_res_i.hit) begin
          f_d        = FAW'(file_idx_i);
          res_slot_d = OUT_IDX_W'(file_idx_i);
          state_d    = S_RESP;
          case (op_q)
            OP_MKFILE: res_status_d = ST_FILE_EXISTS;
            OP_RMFILE: state_d      = S_DEL_RD;
            default:   res_status_d = ST_FOUND;
          endcase
        end else if (file_res_i.miss) begin
          state_d = S_RESP;
          if (op_q != OP_MKFILE) begin
            res_status_d = ST_FILE_MISSING;
          end else if (cnt_q == FCW'(FILE_SLOTS)) begin
            res_status_d = ST_DIR_FULL;
          end else begin
            // Append the file and bump the directory's count.
            file_we_o    = 1'b1;
            dir_we_o     = 1'b1;
            dir_wdata_o  = {cnt_q + FCW'(1), dkey_q};
            res_status_d = ST_FILE_CREATED;
            res_slot_d   = OUT_IDX_W'(cnt_q);
          end
        end
      end

      S_DEL_RD: begin
        // Fetch the last file of the directory.
        file_ctl_o.rd_en = 1'b1;
        state_d          = S_DEL_WR;
      end

      S_DEL_WR: begin
        // Move the last file into the freed slot and shrink the count.
        file_we_o    = 1'b1;
        file_waddr_o = base_q + MAW'(f_q);
        file_wdata_o = file_rdata_i;
        dir_we_o     = 1'b1;
        dir_wdata_o  = {cnt_q - FCW'(1), dkey_q};
        res_status_d = ST_DELETED;
        state_d      = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || rsp_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_dir_d    = res_dir_q;
          out_slot_d   = res_slot_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dirs_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dirs_q      <= dirs_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    dkey_q       <= dkey_d;
    fkey_q       <= fkey_d;
    d_q          <= d_d;
    cnt_q        <= cnt_d;
    base_q       <= base_d;
    f_q          <= f_d;
    res_status_q <= res_status_d;
    res_dir_q    <= res_dir_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_dir_q    <= out_dir_d;
    out_slot_q   <= out_slot_d;
  end

  // The directory count never passes the table size.
  a_dirs_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dirs_q <= DCW'(DIR_SLOTS))
    else $error("tnd_ctrl: directory count overflow");

  // An accepted request always starts with the directory search.
  a_accept_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_DSCAN))
    else $error("tnd_ctrl: request not followed by a directory search");

  // A file is appended only into a directory with room.
  a_file_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (file_we_o && (state_q == S_FSCAN)) |-> (cnt_q < FCW'(FILE_SLOTS)))
    else $error("tnd_ctrl: file written into a full directory");

  // A new result beat only appears after the response step.
  a_resp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("tnd_ctrl: result beat without a response step");

endmodule

>>> hdl/two_level_name_directory.sv
`timescale 1ns / 1ps
// A request passes the directory search, then for file requests the file search; a
// delete adds a read-back. Throughput: one request at a time; the next request is
// taken once the previous result sits in the output register.
// The single read port of each name memory sets the one-name-per-cycle search.
// Reset: clears the directory count and handshake state; memories are not cleared.
// ----------------------------------------------------------------------------
// two_level_name_directory
// Two-level name table: directory names, each holding a list of file names.
// Requests create directories, create, delete or search files; each request
// returns one status beat.
// ----------------------------------------------------------------------------
module two_level_name_directory
  import tnd_pkg::*;
#(
  parameter int unsigned DIR_SLOTS  = 16,
  parameter int unsigned FILE_SLOTS = 16,
  parameter int unsigned NAME_BYTES = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Request stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,   // dir_key[63:0], file_key[127:64]
  input  logic [1:0]   s_axis_tuser_i,   // opcode[1:0]
  // Result stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [15:0]  m_axis_tdata_o    // status[3:0], dir_index[7:4], file_slot[11:8], zero
);

  localparam int unsigned NAME_W = 8 * NAME_BYTES;
  localparam int unsigned DAW    = $clog2(DIR_SLOTS);
  localparam int unsigned DCW    = $clog2(DIR_SLOTS + 1);
  localparam int unsigned FCW    = $clog2(FILE_SLOTS + 1);
  localparam int unsigned MAW    = $clog2(DIR_SLOTS * FILE_SLOTS);
  localparam int unsigned DDW    = FCW + NAME_W;

  scan_ctl_t            dir_ctl;
  scan_res_t            dir_res;
  logic [DCW-1:0]       dir_idx;
  logic [DDW-1:0]       dir_rdata;
  logic [DCW-1:0]       dir_limit;
  logic [NAME_W-1:0]    dir_key;
  logic                 dir_we;
  logic [DAW-1:0]       dir_waddr;
  logic [DDW-1:0]       dir_wdata;
  scan_ctl_t            file_ctl;
  scan_res_t            file_res;
  logic [FCW-1:0]       file_idx;
  logic [NAME_W-1:0]    file_rdata;
  logic [FCW-1:0]       file_limit;
  logic [MAW-1:0]       file_base;
  logic [MAW-1:0]       file_rd_addr;
  logic [NAME_W-1:0]    file_key;
  logic                 file_we;
  logic [MAW-1:0]       file_waddr;
  logic [NAME_W-1:0]    file_wdata;
  logic [STATUS_W-1:0]  rsp_status;
  logic [OUT_IDX_W-1:0] rsp_dir;
  logic [OUT_IDX_W-1:0] rsp_slot;

  // Result beat packing.
  assign m_axis_tdata_o = {4'd0, rsp_slot, rsp_dir, rsp_status};

  // Request sequencer.
  tnd_ctrl #(
    .DIR_SLOTS  (DIR_SLOTS),
    .FILE_SLOTS (FILE_SLOTS),
    .NAME_BYTES (NAME_BYTES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (s_axis_tvalid_i),
    .req_ready_o    (s_axis_tready_o),
    .req_op_i       (s_axis_tuser_i),
    .req_dir_key_i  (s_axis_tdata_i[63:0]),
    .req_file_key_i (s_axis_tdata_i[127:64]),
    .rsp_valid_o    (m_axis_tvalid_o),
    .rsp_ready_i    (m_axis_tready_i),
    .rsp_status_o   (rsp_status),
    .rsp_dir_o      (rsp_dir),
    .rsp_slot_o     (rsp_slot),
    .dir_ctl_o      (dir_ctl),
    .dir_res_i      (dir_res),
    .dir_idx_i      (dir_idx),
    .dir_rdata_i    (dir_rdata),
    .dir_limit_o    (dir_limit),
    .dir_key_o      (dir_key),
    .dir_we_o       (dir_we),
    .dir_waddr_o    (dir_waddr),
    .dir_wdata_o    (dir_wdata),
    .file_ctl_o     (file_ctl),
    .file_res_i     (file_res),
    .file_idx_i     (file_idx),
    .file_rdata_i   (file_rdata),
    .file_limit_o   (file_limit),
    .file_base_o    (file_base),
    .file_rd_addr_o (file_rd_addr),
    .file_key_o     (file_key),
    .file_we_o      (file_we),
    .file_waddr_o   (file_waddr),
    .file_wdata_o   (file_wdata)
  );

  // Directory table: file count above the directory name.
  tnd_table #(
    .DEPTH (DIR_SLOTS),
    .AW    (DAW),
    .IW    (DCW),
    .KW    (NAME_W),
    .DW    (DDW)
  ) u_dir_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (dir_ctl),
    .res_o     (dir_res),
    .key_i     (dir_key),
    .limit_i   (dir_limit),
    .base_i    ({DAW{1'b0}}),
    .rd_addr_i ({DAW{1'b0}}),
    .we_i      (dir_we),
    .waddr_i   (dir_waddr),
    .wdata_i   (dir_wdata),
    .idx_o     (dir_idx),
    .rdata_o   (dir_rdata)
  );

  // File table: one row of FILE_SLOTS names per directory.
  tnd_table #(
    .DEPTH (DIR_SLOTS * FILE_SLOTS),
    .AW    (MAW),
    .IW    (FCW),
    .KW    (NAME_W),
    .DW    (NAME_W)
  ) u_file_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (file_ctl),
    .res_o     (file_res),
    .key_i     (file_key),
    .limit_i   (file_limit),
    .base_i    (file_base),
    .rd_addr_i (file_rd_addr),
    .we_i      (file_we),
    .waddr_i   (file_waddr),
    .wdata_i   (file_wdata),
    .idx_o     (file_idx),
    .rdata_o   (file_rdata)
  );

endmodule
